// ----- rtl/core/dsf_pkg.sv -----
// Shared types, constants and helper functions of the doomed state finder.
package dsf_pkg;

  localparam int unsigned MaxStates = 32;
  localparam int unsigned IdxW      = 5;
  localparam int unsigned CntW      = 6;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 6;

  typedef logic [MaxStates-1:0] row_t;
  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [CntW-1:0]      cnt_t;

  localparam logic [CfgIdxW-1:0] CfgNumStates      = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgAcceptingState = 1'b1;

  localparam logic KindRoot   = 1'b0;
  localparam logic KindDoomed = 1'b1;

  function automatic idx_t lowest_idx(input row_t bits);
    idx_t idx;
    idx = '0;
    for (int i = MaxStates - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = idx_t'(i);
      end
    end
    return idx;
  endfunction

  function automatic row_t state_mask(input cnt_t n);
    row_t m;
    m = '0;
    for (int i = 0; i < MaxStates; i++) begin
      m[i] = (cnt_t'(i) < n);
    end
    return m;
  endfunction

  function automatic row_t one_hot(input idx_t idx);
    return row_t'(1) << idx;
  endfunction

endpackage

// ----- rtl/core/doomed_state_finder.sv -----
// Doomed state finder: reversed adjacency memory, root scan, reachability walk and report.
// Loading takes one edge transfer per cycle while the input is not stalled; an item
// without the final mark gives no result. After the final item come a flush, a root scan
// over the states in use and a reachability walk from the roots, then one result per free
// output cycle and a closing step; the single memory read port sets the pace.
// Reset restores the configuration defaults and clears the row valid bits and all control.
module doomed_state_finder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dsf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dsf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [4:0]                    edge_from_i,
  input  logic [4:0]                    edge_to_i,
  input  logic                          edge_valid_i,
  input  logic                          final_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic [4:0]                    state_index_o,
  output logic                          last_o
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FLUSH,
    ST_SCAN,
    ST_WALK,
    ST_REPORT
  } state_e;

  state_e          state_q, state_d;
  dsf_pkg::cnt_t   num_states_q;
  dsf_pkg::idx_t   accepting_q;

  dsf_pkg::row_t   mem_q [dsf_pkg::MaxStates];
  dsf_pkg::row_t   rdata_q;
  dsf_pkg::idx_t   raddr;
  dsf_pkg::idx_t   rd_addr_q;
  dsf_pkg::row_t   row_valid_q, row_valid_d;

  logic            wr_vld_q, wr_vld_d;
  dsf_pkg::idx_t   wr_row_q, wr_row_d;
  dsf_pkg::idx_t   wr_col_q, wr_col_d;
  logic            fwd_vld_q;
  dsf_pkg::idx_t   fwd_row_q;
  dsf_pkg::row_t   fwd_data_q;
  dsf_pkg::row_t   wr_data;

  dsf_pkg::cnt_t   scan_cnt_q, scan_cnt_d;
  logic            scan_vld_q, scan_vld_d;
  dsf_pkg::row_t   incoming_q, incoming_d;
  logic            exp_vld_q, exp_vld_d;
  dsf_pkg::row_t   visited_q, visited_d;
  dsf_pkg::row_t   pending_q, pending_d;
  dsf_pkg::row_t   rem_roots_q, rem_roots_d;
  dsf_pkg::row_t   rem_doom_q, rem_doom_d;

  logic            out_valid_q, out_valid_d;
  logic            kind_q, kind_d;
  dsf_pkg::idx_t   index_q, index_d;
  logic            last_q, last_d;

  dsf_pkg::cnt_t   n_eff;
  dsf_pkg::row_t   used;
  dsf_pkg::row_t   row_rd;
  dsf_pkg::row_t   roots;
  dsf_pkg::row_t   new_bits;
  dsf_pkg::row_t   rem_roots_nx;
  dsf_pkg::row_t   rem_doom_nx;
  dsf_pkg::idx_t   pick;
  logic            in_acc;
  logic            edge_ok;
  logic            out_free;

  assign n_eff = (num_states_q > dsf_pkg::cnt_t'(dsf_pkg::MaxStates)) ?
                 dsf_pkg::cnt_t'(dsf_pkg::MaxStates) : num_states_q;
  assign used  = dsf_pkg::state_mask(n_eff);

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign edge_ok    = edge_valid_i && ({1'b0, edge_from_i} < n_eff) &&
                      ({1'b0, edge_to_i} < n_eff) && (edge_from_i != accepting_q);

  assign row_rd  = row_valid_q[rd_addr_q] ? rdata_q : '0;
  assign wr_data = ((fwd_vld_q && (fwd_row_q == wr_row_q)) ? fwd_data_q : row_rd) |
                   dsf_pkg::one_hot(wr_col_q);

  assign roots    = used & ~incoming_q & ~dsf_pkg::one_hot(accepting_q);
  assign new_bits = row_rd & used & ~visited_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    raddr       = edge_to_i;
    wr_vld_d    = 1'b0;
    wr_row_d    = edge_to_i;
    wr_col_d    = edge_from_i;
    row_valid_d = row_valid_q;
    scan_cnt_d  = scan_cnt_q;
    scan_vld_d  = 1'b0;
    incoming_d  = incoming_q;
    exp_vld_d   = 1'b0;
    visited_d   = visited_q;
    pending_d   = pending_q;
    rem_roots_d = rem_roots_q;
    rem_doom_d  = rem_doom_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    index_d     = index_q;
    last_d      = last_q;
    pick        = dsf_pkg::lowest_idx(pending_q);
    rem_roots_nx = rem_roots_q;
    rem_doom_nx  = rem_doom_q;

    if (wr_vld_q) begin
      row_valid_d[wr_row_q] = 1'b1;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          wr_vld_d = edge_ok;
          if (final_item_i) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        scan_cnt_d = '0;
        incoming_d = '0;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_cnt_q < n_eff) begin
          raddr      = scan_cnt_q[dsf_pkg::IdxW-1:0];
          scan_vld_d = 1'b1;
          scan_cnt_d = scan_cnt_q + dsf_pkg::cnt_t'(1);
        end
        if (scan_vld_q) begin
          incoming_d = incoming_q | (row_rd & ~dsf_pkg::one_hot(rd_addr_q));
        end
        if ((scan_cnt_q >= n_eff) && !scan_vld_q) begin
          visited_d   = roots;
          pending_d   = roots;
          rem_roots_d = roots;
          state_d     = ST_WALK;
        end
      end
      ST_WALK: begin
        if (pending_q != '0) begin
          raddr     = pick;
          exp_vld_d = 1'b1;
          pending_d = pending_q & ~dsf_pkg::one_hot(pick);
        end
        if (exp_vld_q) begin
          visited_d = visited_q | new_bits;
          pending_d = pending_d | new_bits;
        end
        if ((pending_q == '0) && !exp_vld_q) begin
          rem_doom_d = used & ~visited_q;
          state_d    = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          if (rem_roots_q != '0) begin
            index_d      = dsf_pkg::lowest_idx(rem_roots_q);
            kind_d       = dsf_pkg::KindRoot;
            rem_roots_nx = rem_roots_q & ~dsf_pkg::one_hot(index_d);
            out_valid_d  = 1'b1;
            last_d       = (rem_roots_nx == '0) && (rem_doom_q == '0);
          end else if (rem_doom_q != '0) begin
            index_d     = dsf_pkg::lowest_idx(rem_doom_q);
            kind_d      = dsf_pkg::KindDoomed;
            rem_doom_nx = rem_doom_q & ~dsf_pkg::one_hot(index_d);
            out_valid_d = 1'b1;
            last_d      = (rem_doom_nx == '0);
          end else begin
            state_d = ST_LOAD;
          end
          rem_roots_d = rem_roots_nx;
          rem_doom_d  = rem_doom_nx;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_vld_q) begin
      mem_q[wr_row_q] <= wr_data;
    end
    rdata_q    <= mem_q[raddr];
    rd_addr_q  <= raddr;
    wr_row_q   <= wr_row_d;
    wr_col_q   <= wr_col_d;
    fwd_row_q  <= wr_row_q;
    fwd_data_q <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      num_states_q <= dsf_pkg::cnt_t'(dsf_pkg::MaxStates);
      accepting_q  <= '0;
      row_valid_q  <= '0;
      wr_vld_q     <= 1'b0;
      fwd_vld_q    <= 1'b0;
      scan_cnt_q   <= '0;
      scan_vld_q   <= 1'b0;
      incoming_q   <= '0;
      exp_vld_q    <= 1'b0;
      visited_q    <= '0;
      pending_q    <= '0;
      rem_roots_q  <= '0;
      rem_doom_q   <= '0;
      out_valid_q  <= 1'b0;
      kind_q       <= dsf_pkg::KindRoot;
      index_q      <= '0;
      last_q       <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == dsf_pkg::CfgNumStates)) begin
        num_states_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == dsf_pkg::CfgAcceptingState)) begin
        accepting_q <= cfg_wdata_i[dsf_pkg::IdxW-1:0];
      end
      state_q     <= state_d;
      row_valid_q <= row_valid_d;
      wr_vld_q    <= wr_vld_d;
      fwd_vld_q   <= wr_vld_q;
      scan_cnt_q  <= scan_cnt_d;
      scan_vld_q  <= scan_vld_d;
      incoming_q  <= incoming_d;
      exp_vld_q   <= exp_vld_d;
      visited_q   <= visited_d;
      pending_q   <= pending_d;
      rem_roots_q <= rem_roots_d;
      rem_doom_q  <= rem_doom_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      index_q     <= index_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign state_index_o = index_q;
  assign last_o        = last_q;

  // A row write always comes from an edge transfer accepted in the previous cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_vld_q |-> $past(in_acc))
    else $error("adjacency write without a preceding edge transfer");

  // States waiting for expansion are always already marked as visited.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ((pending_q & ~visited_q) == '0))
    else $error("pending state not marked visited");

  // Row reads of the walk only happen while walking.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_vld_q |-> (state_q == ST_WALK))
    else $error("walk read outside the walk");

  // Reported states never lie outside the states in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REPORT) |-> (((rem_roots_q | rem_doom_q) & ~used) == '0))
    else $error("report mask outside the states in use");

endmodule

// ----- dv/dsf_tb_pkg.sv -----
// Scoreboard of the doomed state finder regression: edge store, reachability prediction, checks.
package dsf_tb_pkg;

  typedef struct packed {
    logic          kind;
    dsf_pkg::idx_t state;
    logic          last;
  } report_t;

  class doom_scoreboard;
    dsf_pkg::row_t rev_rows[dsf_pkg::MaxStates];
    dsf_pkg::cnt_t num_states;
    dsf_pkg::idx_t accepting;
    report_t       awaited_q[$];
    int            errors;
    int            runs;
    int            edges_seen;
    int            roots_seen;
    int            doomed_seen;

    function new();
      foreach (rev_rows[i]) rev_rows[i] = '0;
      num_states  = dsf_pkg::cnt_t'(dsf_pkg::MaxStates);
      accepting   = '0;
      errors      = 0;
      runs        = 0;
      edges_seen  = 0;
      roots_seen  = 0;
      doomed_seen = 0;
    endfunction

    function void write_reg(logic [dsf_pkg::CfgIdxW-1:0] idx,
                            logic [dsf_pkg::CfgDataW-1:0] data);
      if (idx == dsf_pkg::CfgNumStates) begin
        num_states = dsf_pkg::cnt_t'(data);
      end else if (idx == dsf_pkg::CfgAcceptingState) begin
        accepting = data[dsf_pkg::IdxW-1:0];
      end
    endfunction

    function int states_in_use();
      return (num_states > dsf_pkg::MaxStates) ? int'(dsf_pkg::MaxStates) : int'(num_states);
    endfunction

    // Stores the edge of an accepted transfer and, on the final mark, queues the run's reports.
    function void note_item(dsf_pkg::idx_t src, dsf_pkg::idx_t dst, logic has_edge, logic fin);
      int            n;
      int            total;
      int            emitted;
      logic          is_root;
      dsf_pkg::row_t used;
      dsf_pkg::row_t roots;
      dsf_pkg::row_t reached;
      dsf_pkg::row_t prior;
      report_t       r;
      n = states_in_use();
      if (has_edge) edges_seen++;
      if (has_edge && src < n && dst < n && src != accepting) rev_rows[dst][src] = 1'b1;
      if (!fin) return;
      runs++;
      used  = '0;
      roots = '0;
      for (int s = 0; s < n; s++) used[s] = 1'b1;
      for (int s = 0; s < n; s++) begin
        is_root = (s != accepting);
        for (int j = 0; j < n; j++) begin
          if (j != s && rev_rows[j][s]) is_root = 1'b0;
        end
        roots[s] = is_root;
      end
      reached = roots;
      do begin
        prior = reached;
        for (int s = 0; s < n; s++) begin
          if (reached[s]) reached |= rev_rows[s] & used;
        end
      end while (reached != prior);
      total   = $countones(roots) + $countones(used & ~reached);
      emitted = 0;
      for (int s = 0; s < n; s++) begin
        if (roots[s]) begin
          emitted++;
          r.kind  = dsf_pkg::KindRoot;
          r.state = dsf_pkg::idx_t'(s);
          r.last  = (emitted == total);
          awaited_q = {awaited_q, r};
        end
      end
      for (int s = 0; s < n; s++) begin
        if (used[s] && !reached[s]) begin
          emitted++;
          r.kind  = dsf_pkg::KindDoomed;
          r.state = dsf_pkg::idx_t'(s);
          r.last  = (emitted == total);
          awaited_q = {awaited_q, r};
        end
      end
    endfunction

    function void check_result(logic kind, dsf_pkg::idx_t state, logic last);
      report_t want;
      if (awaited_q.size() == 0) begin
        $error("result with none awaited: kind %0d state_index %0d last %0d", kind, state, last);
        errors++;
        return;
      end
      want = awaited_q.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, kind);
        errors++;
      end
      if (state !== want.state) begin
        $error("state_index: expected %0d, actual %0d", want.state, state);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, last);
        errors++;
      end
      if (want.kind == dsf_pkg::KindRoot) begin
        roots_seen++;
      end else begin
        doomed_seen++;
      end
    endfunction

    function void close_out();
      if (awaited_q.size() != 0) begin
        $error("%0d expected results never arrived", awaited_q.size());
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- dv/tb_top.sv -----
// Top of the doomed state finder regression: clock, reset, stimulus, output stalls and checks.
module tb_top;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 200;
  localparam int RandomItems  = 150;
  localparam int HoldCycles   = 400;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [dsf_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [dsf_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [4:0]                   edge_from_i;
  logic [4:0]                   edge_to_i;
  logic                         edge_valid_i;
  logic                         final_item_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic                         kind_o;
  logic [4:0]                   state_index_o;
  logic                         last_o;

  int send_idle_pct = 36;
  int recv_idle_pct = 51;
  int hold_cycles   = 0;
  int cycle_count   = 0;

  dsf_tb_pkg::doom_scoreboard sb;

  doomed_state_finder dut (.*);

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("doomed_state_finder regression: fail");
    $finish;
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i = 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(kind_o, state_index_o, last_o);
    end
  end

  task automatic write_reg(input logic [dsf_pkg::CfgIdxW-1:0] idx,
                           input logic [dsf_pkg::CfgDataW-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_item(input dsf_pkg::idx_t src, input dsf_pkg::idx_t dst,
                           input logic has_edge, input logic fin);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i   = 1'b1;
    edge_from_i  = src;
    edge_to_i    = dst;
    edge_valid_i = has_edge;
    final_item_i = fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(src, dst, has_edge, fin);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic settle();
    while (sb.awaited_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    int            counted;
    int            graphs;
    int            n;
    int            hops;
    int            pick;
    bit            hold_done;
    dsf_pkg::idx_t src;
    dsf_pkg::idx_t dst;
    logic          has_edge;
    logic [5:0]    ns;
    sb           = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = dsf_pkg::CfgNumStates;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    edge_from_i  = '0;
    edge_to_i    = '0;
    edge_valid_i = 1'b0;
    final_item_i = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: extreme indices, an empty item, a self loop, an edge out of the
    // accepting state, and an edge carried by the final item.
    send_item(5'd31, 5'd0, 1'b1, 1'b0);
    send_item(5'd31, 5'd31, 1'b0, 1'b0);
    send_item(5'd5, 5'd5, 1'b1, 1'b0);
    send_item(5'd0, 5'd7, 1'b1, 1'b0);
    send_item(5'd2, 5'd3, 1'b1, 1'b0);
    send_item(5'd3, 5'd4, 1'b1, 1'b0);
    send_item(5'd30, 5'd31, 1'b1, 1'b1);
    settle();
    // With no states in use a run reports nothing.
    write_reg(dsf_pkg::CfgNumStates, 6'd0);
    send_item(5'd1, 5'd2, 1'b1, 1'b1);
    settle();
    // A state count above the maximum saturates.
    write_reg(dsf_pkg::CfgNumStates, 6'h3f);
    write_reg(dsf_pkg::CfgAcceptingState, 6'h3f);
    send_item(5'd0, 5'd0, 1'b0, 1'b1);
    settle();
    write_reg(dsf_pkg::CfgNumStates, 6'd1);
    write_reg(dsf_pkg::CfgAcceptingState, 6'd0);
    send_item(5'd0, 5'd0, 1'b1, 1'b1);
    settle();
    // An accepting state outside the range excludes nothing.
    write_reg(dsf_pkg::CfgAcceptingState, 6'd20);
    send_item(5'd0, 5'd0, 1'b0, 1'b1);
    settle();
    write_reg(dsf_pkg::CfgNumStates, 6'd4);
    write_reg(dsf_pkg::CfgAcceptingState, 6'd2);
    send_item(5'd4, 5'd1, 1'b1, 1'b0);
    send_item(5'd1, 5'd20, 1'b1, 1'b0);
    send_item(5'd1, 5'd3, 1'b1, 1'b0);
    send_item(5'd2, 5'd1, 1'b1, 1'b0);
    send_item(5'd0, 5'd1, 1'b1, 1'b1);
    settle();

    counted   = 0;
    graphs    = 0;
    hold_done = 1'b0;
    while (counted < RandomItems) begin
      if (counted < RandomItems / 3) begin
        send_idle_pct = 36;
        recv_idle_pct = 51;
      end else if (counted < 2 * RandomItems / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (graphs == 0 || (hold_cycles == 0 && $urandom_range(2) == 0)) begin
        settle();
        case ($urandom_range(9))
          0:       ns = 6'd0;
          1:       ns = 6'd1;
          2:       ns = 6'd32;
          3:       ns = 6'($urandom_range(63, 33));
          default: ns = 6'($urandom_range(31, 2));
        endcase
        write_reg(dsf_pkg::CfgNumStates, ns);
        write_reg(dsf_pkg::CfgAcceptingState, 6'($urandom_range(63)));
      end
      if (!hold_done && counted >= 20) begin
        // The output side holds off while transfers keep coming, so the block backs up.
        @(posedge clk_i);
        hold_cycles = HoldCycles;
        @(negedge clk_i);
        hold_done = 1'b1;
      end
      n    = sb.states_in_use();
      hops = $urandom_range(8, 1);
      for (int e = 0; e < hops; e++) begin
        pick = $urandom_range(99);
        if (pick < 60 && n >= 2) begin
          src = dsf_pkg::idx_t'($urandom_range(n - 2));
          dst = dsf_pkg::idx_t'($urandom_range(n - 1, int'(src) + 1));
        end else if (pick < 70) begin
          src = dsf_pkg::idx_t'($urandom_range(31));
          dst = src;
        end else begin
          src = dsf_pkg::idx_t'($urandom_range(31));
          dst = dsf_pkg::idx_t'($urandom_range(31));
        end
        has_edge = ($urandom_range(9) != 0);
        send_item(src, dst, has_edge, 1'b0);
        counted++;
      end
      send_item(dsf_pkg::idx_t'($urandom_range(31)), dsf_pkg::idx_t'($urandom_range(31)),
                1'($urandom_range(1)), 1'b1);
      counted++;
      graphs++;
    end

    settle();
    sb.close_out();
    $display("Ran %0d walks over %0d edge transfers; checked %0d roots and %0d doomed states.",
             sb.runs, sb.edges_seen, sb.roots_seen, sb.doomed_seen);
    if (sb.errors == 0) begin
      $display("doomed_state_finder regression: pass");
    end else begin
      $display("doomed_state_finder regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/dsf_pkg.sv
rtl/core/doomed_state_finder.sv
dv/dsf_tb_pkg.sv
dv/tb_top.sv
